>>> rtl/tpcv_pkg.sv
`timescale 1ns / 1ps
package tpcv_pkg;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_TOP      = 16'h8000;
  localparam logic [15:0] HEADER_RESET = 16'h4B4B;
  localparam logic [7:0]  LENGTH_RESET = 8'd26;
  localparam logic [7:0]  COUNT_MAX    = 8'd255;

  localparam int unsigned PADDR_W = 4;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_PACKET_LENGTH = 2'd0;
  localparam logic [1:0] REG_HEADER_WORD   = 2'd1;
  localparam logic [1:0] REG_MOCK_ACCEPT   = 2'd2;

  typedef logic [1:0] verdict_t;
  localparam verdict_t VERDICT_ACCEPTED     = 2'd0;
  localparam verdict_t VERDICT_WRONG_LENGTH = 2'd1;
  localparam verdict_t VERDICT_BAD_HEADER   = 2'd2;
  localparam verdict_t VERDICT_CRC_MISMATCH = 2'd3;

  // CRC-16/CCITT-FALSE update for one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/tpcv_byte_if.sv
`timescale 1ns / 1ps
interface tpcv_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

>>> rtl/tpcv_report_if.sv
`timescale 1ns / 1ps
interface tpcv_report_if import tpcv_pkg::*;;
  logic        valid;
  logic        ready;
  verdict_t    verdict;
  logic [15:0] node_number;
  logic [15:0] received_check;
  logic [15:0] computed_check;

  modport source (output valid, output verdict, output node_number,
                  output received_check, output computed_check, input ready);
  modport sink (input valid, input verdict, input node_number,
                input received_check, input computed_check, output ready);
endinterface

>>> rtl/telemetry_packet_crc_validator.sv
`timescale 1ns / 1ps
// Telemetry packet checker: takes one received radio byte per word on rx_byte, each
// with a last_byte flag, runs CRC-16/CCITT-FALSE (init 0xFFFF, poly 0x1021, MSB
// first) over all bytes but the trailing two, and on the last byte of a packet
// sends one word on report: verdict (0 accepted, 1 wrong length, 2 bad header,
// 3 CRC mismatch, checked in that order), node number (bytes 2..3, little
// endian), received CRC (last two bytes, little endian) and computed CRC.
// A byte is taken every cycle unless the report register stalls; a report is
// registered (the last byte sits in the input register, then the report
// register loads). Only a stalled report register holds up the input side, and
// only when the next byte to be processed is itself a last byte. Registers over
// APB at 0x0 packet_length (reset 26), 0x4 header_word (reset 0x4B4B), 0x8
// mock_accept (reset 1; when set a received CRC of 0xFFFF passes); write them
// only while no packet is in flight. The byte counter saturates at 255.
module telemetry_packet_crc_validator
  import tpcv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  tpcv_byte_if.sink          rx_byte,
  tpcv_report_if.source      report
);

  // ---------------- configuration registers ----------------
  logic [7:0]  packet_length;
  logic [15:0] header_word;
  logic        mock_accept;
  logic        cfg_write;
  logic [1:0]  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_length <= LENGTH_RESET;
      header_word   <= HEADER_RESET;
      mock_accept   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PACKET_LENGTH: packet_length <= pwdata[7:0];
        REG_HEADER_WORD:   header_word   <= pwdata[15:0];
        REG_MOCK_ACCEPT:   mock_accept   <= pwdata[0];
        default: ;  // unmapped, write ignored
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_PACKET_LENGTH: prdata = {24'h0, packet_length};
      REG_HEADER_WORD:   prdata = {16'h0, header_word};
      REG_MOCK_ACCEPT:   prdata = {31'h0, mock_accept};
      default:           prdata = 32'h0;
    endcase
  end

  // ---------------- input register ----------------
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       out_free;
  logic       proc;

  // report register can take a new word this cycle
  assign out_free      = !report.valid || report.ready;
  // a plain byte always moves on; a last byte needs the report slot
  assign proc          = s1_valid && (!s1_last || out_free);
  assign rx_byte.ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx_byte.ready) begin
      s1_valid <= rx_byte.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_byte.ready && rx_byte.valid) begin
      s1_byte <= rx_byte.byte_value;
      s1_last <= rx_byte.last_byte;
    end
  end

  // ---------------- per-packet state ----------------
  logic [7:0]  byte_count,  byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] header_seen, header_seen_next;
  logic [15:0] node_seen,   node_seen_next;
  logic [15:0] check_seen,  check_seen_next;
  logic        crc_take;
  verdict_t    verdict_next;

  // bytes at positions below packet_length - 2 enter the CRC
  assign crc_take = ({1'b0, byte_count} + 9'd2) < {1'b0, packet_length};

  always_comb begin
    header_seen_next = header_seen;
    node_seen_next   = node_seen;
    unique case (byte_count)
      8'd0:    header_seen_next = {header_seen[15:8], s1_byte};
      8'd1:    header_seen_next = {s1_byte, header_seen[7:0]};
      8'd2:    node_seen_next   = {node_seen[15:8], s1_byte};
      8'd3:    node_seen_next   = {s1_byte, node_seen[7:0]};
      default: ;
    endcase
    running_crc_next = crc_take ? crc_byte(running_crc, s1_byte) : running_crc;
    check_seen_next  = {s1_byte, check_seen[15:8]};
    byte_count_next  = (byte_count == COUNT_MAX) ? byte_count : byte_count + 8'd1;

    priority if (byte_count_next != packet_length) begin
      verdict_next = VERDICT_WRONG_LENGTH;
    end else if (header_seen_next != header_word) begin
      verdict_next = VERDICT_BAD_HEADER;
    end else if (check_seen_next == running_crc_next
                 || (mock_accept && check_seen_next == CRC_INIT)) begin
      verdict_next = VERDICT_ACCEPTED;
    end else begin
      verdict_next = VERDICT_CRC_MISMATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= 8'd0;
      running_crc <= CRC_INIT;
      header_seen <= 16'h0;
      node_seen   <= 16'h0;
      check_seen  <= 16'h0;
    end else if (proc) begin
      if (s1_last) begin
        // packet done, start over
        byte_count  <= 8'd0;
        running_crc <= CRC_INIT;
        header_seen <= 16'h0;
        node_seen   <= 16'h0;
        check_seen  <= 16'h0;
      end else begin
        byte_count  <= byte_count_next;
        running_crc <= running_crc_next;
        header_seen <= header_seen_next;
        node_seen   <= node_seen_next;
        check_seen  <= check_seen_next;
      end
    end
  end

  // ---------------- report register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (proc && s1_last) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_last) begin
      report.verdict        <= verdict_next;
      report.node_number    <= node_seen_next;
      report.received_check <= check_seen_next;
      report.computed_check <= running_crc_next;
    end
  end

`ifndef SYNTH
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    proc && s1_last |=> byte_count == 8'd0 && running_crc == CRC_INIT)
    else $error("packet state not cleared after last byte");

  a_report_loaded: assert property (@(posedge clk) disable iff (rst)
    proc && s1_last |=> report.valid)
    else $error("last byte processed without a report");

  a_fresh_packet: assert property (@(posedge clk) disable iff (rst)
    byte_count == 8'd0 |-> running_crc == CRC_INIT && header_seen == 16'h0
                           && check_seen == 16'h0)
    else $error("empty packet carries stale state");

  a_stalled_byte_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !proc |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("pending byte lost while report stalled");
`endif

endmodule
